/* src/sensor_frame_deframer_core_defines.svh */
// ----------------------------------------------------------------------------
// sensor frame deframer assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define SENSOR_FRAME_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication
`define SFD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfd assertion failed");

// next-cycle implication
`define SFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfd assertion failed");

`endif

/* src/sfd_pkg.sv */
// ----------------------------------------------------------------------------
// sfd_pkg
// Frame codes and parser phase encodings of the sensor frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // sync pair
  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;

  // header and group sizes
  localparam int SKIP_BYTES        = 4;
  localparam int BYTES_PER_CHANNEL = 4;
  localparam logic [1:0] SKIP_LAST = 2'(SKIP_BYTES - 1);
  localparam logic [1:0] LANE_LAST = 2'(BYTES_PER_CHANNEL - 1);

  // parser phases
  localparam logic [2:0] PH_HUNT_FIRST  = 3'd0;
  localparam logic [2:0] PH_HUNT_SECOND = 3'd1;
  localparam logic [2:0] PH_SKIP        = 3'd2;
  localparam logic [2:0] PH_DATA        = 3'd3;
  localparam logic [2:0] PH_CHECK       = 3'd4;

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] word_t;

endpackage

/* src/sfd_channels_if.sv */
// ----------------------------------------------------------------------------
// sfd channel interfaces
// Valid/ready byte input channel and result output channel.
// ----------------------------------------------------------------------------
interface sfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  channel;
  logic [31:0] value_word;
  logic        frame_good;
  logic        last;

  modport source (output valid, output channel, output value_word, output frame_good,
                  output last, input ready);
  modport sink   (input valid, input channel, input value_word, input frame_good,
                  input last, output ready);
endinterface

/* src/sensor_frame_deframer_core.sv */
// ----------------------------------------------------------------------------
// sensor_frame_deframer_core
// Sync-header frame parser with additive checksum for a force sensor link.
// ----------------------------------------------------------------------------
// in_chan takes one received byte per transfer. The parser hunts for 0xAA 0x55,
// drops two length and two sample-number bytes, then collects CHANNELS groups
// of four data bytes into a word memory (one 32-bit entry per channel) while
// keeping an 8-bit wrapping sum. The next byte is the checksum.
// out_chan gives one word per channel (little-endian, frame_good set) on a
// match, or a single error word (channel 0, value 0, frame_good clear) on a
// mismatch; last marks the final word of the frame.
// Throughput: one input byte per cycle; results leave at one per cycle.
// The first result follows the checksum byte through the drain-active
// register, the memory read register and the output register.
// Input stalls come from the drain of the previous frame: the checksum byte
// waits until that drain has been issued, and a data byte that completes a
// word waits while that memory entry is still unread. At full rate on both
// sides neither case occurs for CHANNELS up to 12.
// When out_chan.ready is low, results hold in the output and read stages and
// the drain pauses. Reset (synchronous rst_n) returns to sync hunt and drops
// any undelivered results; the word memory is not cleared.
// ----------------------------------------------------------------------------
`include "sensor_frame_deframer_core_defines.svh"

module sensor_frame_deframer_core
  import sfd_pkg::*;
#(
  parameter int CHANNELS = 3
) (
  input logic          clk,
  input logic          rst_n,
  sfd_byte_if.sink     in_chan,
  sfd_result_if.source out_chan
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

  // parser state
  logic [2:0]       phase_r, phase_nxt;
  logic [1:0]       lane_r, lane_nxt;
  logic [IDX_W-1:0] wr_chan_r, wr_chan_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [23:0]      hold_r;

  // word memory
  word_t            mem [CHANNELS];
  word_t            rd_data_r;
  logic             mem_we;

  // drain control
  logic             drain_active_r, drain_active_nxt;
  logic             drain_good_r, drain_good_nxt;
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic             drain_start;
  logic             rd_issue;
  logic             rd_last;
  logic [IDX_W+1:0] rd_ptr_ext;

  // read stage and output stage
  logic             s1_valid_r, s1_valid_nxt;
  logic [1:0]       s1_chan_r;
  logic             s1_good_r;
  logic             s1_last_r;
  logic             s1_move;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_chan_r;
  word_t            out_value_r;
  logic             out_good_r;
  logic             out_last_r;

  logic             in_ready;
  logic             in_fire;
  byte_t            b;

  assign b = in_chan.rx_byte;

  // input back pressure from an unfinished drain
  always_comb begin
    unique case (phase_r)
      PH_CHECK: in_ready = !drain_active_r;
      PH_DATA:  in_ready = !((lane_r == LANE_LAST) && drain_active_r &&
                             (wr_chan_r >= rd_ptr_r));
      default:  in_ready = 1'b1;
    endcase
  end

  assign in_fire       = in_chan.valid && in_ready;
  assign in_chan.ready = in_ready;

  // frame parser
  always_comb begin
    phase_nxt   = phase_r;
    lane_nxt    = lane_r;
    wr_chan_nxt = wr_chan_r;
    sum_nxt     = sum_r;
    mem_we      = 1'b0;
    drain_start = 1'b0;
    if (in_fire) begin
      unique case (phase_r)
        PH_HUNT_FIRST: begin
          if (b == SYNC_FIRST) phase_nxt = PH_HUNT_SECOND;
        end
        PH_HUNT_SECOND: begin
          if (b == SYNC_SECOND) begin
            phase_nxt = PH_SKIP;
            lane_nxt  = 2'd0;
          end else if (b != SYNC_FIRST) begin
            phase_nxt = PH_HUNT_FIRST;
          end
        end
        PH_SKIP: begin
          lane_nxt = lane_r + 2'd1;
          if (lane_r == SKIP_LAST) begin
            phase_nxt   = PH_DATA;
            lane_nxt    = 2'd0;
            sum_nxt     = 8'd0;
            wr_chan_nxt = '0;
          end
        end
        PH_DATA: begin
          sum_nxt  = sum_r + b;
          lane_nxt = lane_r + 2'd1;
          if (lane_r == LANE_LAST) begin
            mem_we = 1'b1;
            if (wr_chan_r == LAST_IDX) begin
              phase_nxt   = PH_CHECK;
              wr_chan_nxt = '0;
            end else begin
              wr_chan_nxt = wr_chan_r + 1'b1;
            end
          end
        end
        PH_CHECK: begin
          drain_start = 1'b1;
          phase_nxt   = PH_HUNT_FIRST;
          sum_nxt     = 8'd0;
        end
        default: begin
          phase_nxt = PH_HUNT_FIRST;
          sum_nxt   = 8'd0;
        end
      endcase
    end
  end

  // drain sequencing through the read stage
  assign s1_move    = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign rd_issue   = drain_active_r && (!s1_valid_r || s1_move);
  assign rd_last    = !drain_good_r || (rd_ptr_r == LAST_IDX);
  assign rd_ptr_ext = {2'b00, rd_ptr_r};

  always_comb begin
    drain_active_nxt = drain_active_r;
    drain_good_nxt   = drain_good_r;
    rd_ptr_nxt       = rd_ptr_r;
    if (drain_start) begin
      drain_active_nxt = 1'b1;
      drain_good_nxt   = (b == sum_r);
      rd_ptr_nxt       = '0;
    end else if (rd_issue) begin
      if (rd_last) drain_active_nxt = 1'b0;
      else         rd_ptr_nxt       = rd_ptr_r + 1'b1;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (rd_issue)     s1_valid_nxt = 1'b1;
    else if (s1_move) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (s1_move)             out_valid_nxt = 1'b1;
    else if (out_chan.ready) out_valid_nxt = 1'b0;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HUNT_FIRST;
      lane_r         <= 2'd0;
      wr_chan_r      <= '0;
      sum_r          <= 8'd0;
      drain_active_r <= 1'b0;
      drain_good_r   <= 1'b0;
      rd_ptr_r       <= '0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      lane_r         <= lane_nxt;
      wr_chan_r      <= wr_chan_nxt;
      sum_r          <= sum_nxt;
      drain_active_r <= drain_active_nxt;
      drain_good_r   <= drain_good_nxt;
      rd_ptr_r       <= rd_ptr_nxt;
      s1_valid_r     <= s1_valid_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // byte assembly of the current group
  always_ff @(posedge clk) begin
    if (in_fire && (phase_r == PH_DATA)) begin
      case (lane_r)
        2'd0:    hold_r[7:0]   <= b;
        2'd1:    hold_r[15:8]  <= b;
        2'd2:    hold_r[23:16] <= b;
        default: hold_r        <= hold_r;
      endcase
    end
  end

  // word memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_chan_r] <= {b, hold_r};
    if (rd_issue) rd_data_r <= mem[rd_ptr_r];
  end

  // read stage tags and output register
  always_ff @(posedge clk) begin
    if (rd_issue) begin
      s1_chan_r <= rd_ptr_ext[1:0];
      s1_good_r <= drain_good_r;
      s1_last_r <= rd_last;
    end
    if (s1_move) begin
      out_chan_r  <= s1_chan_r;
      out_value_r <= s1_good_r ? rd_data_r : '0;
      out_good_r  <= s1_good_r;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.channel    = out_chan_r;
  assign out_chan.value_word = out_value_r;
  assign out_chan.frame_good = out_good_r;
  assign out_chan.last       = out_last_r;

  // checks
  `SFD_ASSERT_IMP(a_no_overtake, mem_we && drain_active_r, wr_chan_r < rd_ptr_r)
  `SFD_ASSERT_NEXT(a_check_starts_drain, in_fire && (phase_r == PH_CHECK), drain_active_r)
  `SFD_ASSERT_IMP(a_error_single, s1_valid_r && !s1_good_r, s1_last_r && (s1_chan_r == 2'd0))
  `SFD_ASSERT_IMP(a_error_zero, out_valid_r && !out_good_r, out_value_r == '0)

endmodule
